### design/assert_macros.svh
// Assertion macros shared by the key count table RTL.
// Included by modules that carry concurrent checks; empty under SYNTH.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define KCT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("kct assertion failed");
`define KCT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("kct forbidden condition");
`else
`define KCT_ASSERT(lbl, prop)
`define KCT_NEVER(lbl, cond)
`endif
`endif

### design/kct_pkg.sv
// Shared constants, codes and types of the key count table.
// No dependencies; used by kct_cell and key_count_table_with_mode_report.
`default_nettype none
package kct_pkg;

  localparam int TABLE_DEPTH  = 64;
  localparam int COUNT_BITS   = 16;
  localparam int REPORT_LIMIT = 64;
  localparam int KEY_W        = 16;
  localparam int OUT_CNT_W    = 16;
  localparam int IDX_W        = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int USED_W       = $clog2(TABLE_DEPTH + 1);
  localparam int RPT_W        = $clog2(REPORT_LIMIT + 1);

  typedef enum logic [2:0] {
    ST_EXISTING = 3'd0,
    ST_NEW      = 3'd1,
    ST_FULL     = 3'd2,
    ST_REPORT   = 3'd3,
    ST_EMPTY    = 3'd4
  } status_e;

  typedef enum logic {
    OP_COUNT  = 1'b0,
    OP_REPORT = 1'b1
  } op_e;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_ONE   = 4'b0010,
    S_SCAN  = 4'b0100,
    S_FLUSH = 4'b1000
  } state_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic              shift;
    logic              upd;
    logic              append;
    logic [KEY_W-1:0]  key;
    logic [USED_W-1:0] used;
  } cell_cmd_t;

  function automatic logic [OUT_CNT_W-1:0] cnt_out(input logic [COUNT_BITS-1:0] c);
    logic [31:0] ext;
    ext = 32'(c);
    return ext[OUT_CNT_W-1:0];
  endfunction

endpackage
`default_nettype wire

### design/key_count_table_with_mode_report.sv
// Top level of the key count table: ring of kct_cell slots plus controller.
// Depends on kct_pkg, kct_cell and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
// Keeps up to TABLE_DEPTH two-character keys with saturating counts in
// arrival order and a running maximum. A count beat passes an accept state
// and one commit state in which every slot compares its key in parallel. A
// report beat walks the table by rotating the whole ring of slots one
// position per cycle past the head slot while the output is not stalled, in
// an accept step, one full turn and a final flush; an empty table answers
// from the commit state. Input is taken only between items; a finished
// result sits in the output register while the next beat is accepted.
// Table storage needs no clearing after reset.
module key_count_table_with_mode_report (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,  // key_first[7:0], key_second[15:8]
  input  wire logic [0:0]  s_axis_tuser,  // operation[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic      [31:0] m_axis_tdata,  // out_key_first[7:0], out_key_second[15:8],
                                          // out_count[31:16]
  output logic      [2:0]  m_axis_tuser,  // status[2:0]
  output logic             m_axis_tlast
);

  localparam int D  = kct_pkg::TABLE_DEPTH;
  localparam int CB = kct_pkg::COUNT_BITS;
  localparam int KW = kct_pkg::KEY_W;
  localparam int OW = kct_pkg::OUT_CNT_W;
  localparam int UW = kct_pkg::USED_W;
  localparam int RW = kct_pkg::RPT_W;

  kct_pkg::state_e         state_q, state_d;
  logic                    op_q, op_d;
  logic [KW-1:0]           key_q, key_d;
  logic [UW-1:0]           used_q, used_d;
  logic [CB-1:0]           max_q, max_d;
  logic [UW-1:0]           stp_q, stp_d;
  logic [RW-1:0]           n_q, n_d;
  logic                    pend_vld_q, pend_vld_d;
  logic [KW-1:0]           pend_key_q, pend_key_d;
  logic [OW-1:0]           pend_cnt_q, pend_cnt_d;
  logic                    out_vld_q, out_vld_d;
  kct_pkg::status_e        out_st_q, out_st_d;
  logic [KW-1:0]           out_key_q, out_key_d;
  logic [OW-1:0]           out_cnt_q, out_cnt_d;
  logic                    out_last_q, out_last_d;

  kct_pkg::cell_cmd_t      cmd;
  logic [KW-1:0]           cell_key [D];
  logic [CB-1:0]           cell_cnt [D];
  logic [CB-1:0]           cell_inc [D];
  logic [D-1:0]            hits;
  logic                    hit_any, full, ostall, head_match;
  logic [CB-1:0]           hit_cnt;
  logic [7:0]              in_first, in_second;

  for (genvar g = 0; g < D; g++) begin : g_cell
    localparam int NX = (g + 1) % D;
    kct_cell u_cell (
      .clk_i     (clk_i),
      .idx_i     (kct_pkg::IDX_W'(g)),
      .cmd_i     (cmd),
      .nbr_key_i (cell_key[NX]),
      .nbr_cnt_i (cell_cnt[NX]),
      .key_o     (cell_key[g]),
      .cnt_o     (cell_cnt[g]),
      .hit_o     (hits[g]),
      .inc_cnt_o (cell_inc[g])
    );
  end

  always_comb begin
    hit_cnt = '0;
    for (int i = 0; i < D; i++) begin
      hit_cnt = hit_cnt | cell_inc[i];
    end
  end

  assign hit_any = |hits;
  assign full    = used_q == UW'(D);
  assign ostall  = out_vld_q && !m_axis_tready;
  assign head_match = (stp_q < used_q) && (cell_cnt[0] == max_q) &&
                      (n_q < RW'(kct_pkg::REPORT_LIMIT));

  assign in_first  = s_axis_tdata[7:0];
  assign in_second = (in_first == 8'd0) ? 8'd0 : s_axis_tdata[15:8];

  assign s_axis_tready = state_q == kct_pkg::S_IDLE;

  always_comb begin
    state_d    = state_q;
    op_d       = op_q;
    key_d      = key_q;
    used_d     = used_q;
    max_d      = max_q;
    stp_d      = stp_q;
    n_d        = n_q;
    pend_vld_d = pend_vld_q;
    pend_key_d = pend_key_q;
    pend_cnt_d = pend_cnt_q;
    out_vld_d  = out_vld_q && !m_axis_tready;
    out_st_d   = out_st_q;
    out_key_d  = out_key_q;
    out_cnt_d  = out_cnt_q;
    out_last_d = out_last_q;
    cmd.shift  = 1'b0;
    cmd.upd    = 1'b0;
    cmd.append = 1'b0;
    cmd.key    = key_q;
    cmd.used   = used_q;

    unique case (state_q)
      kct_pkg::S_IDLE: begin
        if (s_axis_tvalid) begin
          op_d  = s_axis_tuser[0];
          key_d = {in_first, in_second};
          stp_d = '0;
          n_d   = '0;
          pend_vld_d = 1'b0;
          if (s_axis_tuser[0] == kct_pkg::OP_REPORT && used_q != '0) begin
            state_d = kct_pkg::S_SCAN;
          end else begin
            state_d = kct_pkg::S_ONE;
          end
        end
      end
      kct_pkg::S_ONE: begin
        if (!ostall) begin
          out_vld_d  = 1'b1;
          out_last_d = 1'b1;
          state_d    = kct_pkg::S_IDLE;
          if (op_q == kct_pkg::OP_REPORT) begin
            out_st_d  = kct_pkg::ST_EMPTY;
            out_key_d = '0;
            out_cnt_d = '0;
          end else if (hit_any) begin
            cmd.upd   = 1'b1;
            out_st_d  = kct_pkg::ST_EXISTING;
            out_key_d = key_q;
            out_cnt_d = kct_pkg::cnt_out(hit_cnt);
            if (hit_cnt > max_q) begin
              max_d = hit_cnt;
            end
          end else if (full) begin
            out_st_d  = kct_pkg::ST_FULL;
            out_key_d = key_q;
            out_cnt_d = '0;
          end else begin
            cmd.append = 1'b1;
            used_d     = used_q + UW'(1);
            out_st_d   = kct_pkg::ST_NEW;
            out_key_d  = key_q;
            out_cnt_d  = OW'(1);
            if (max_q == '0) begin
              max_d = CB'(1);
            end
          end
        end
      end
      kct_pkg::S_SCAN: begin
        if (!ostall) begin
          cmd.shift = 1'b1;
          stp_d     = stp_q + UW'(1);
          if (head_match) begin
            if (pend_vld_q) begin
              out_vld_d  = 1'b1;
              out_st_d   = kct_pkg::ST_REPORT;
              out_key_d  = pend_key_q;
              out_cnt_d  = pend_cnt_q;
              out_last_d = 1'b0;
            end
            pend_vld_d = 1'b1;
            pend_key_d = cell_key[0];
            pend_cnt_d = kct_pkg::cnt_out(cell_cnt[0]);
            n_d        = n_q + RW'(1);
          end
          if (stp_q == UW'(D - 1)) begin
            state_d = kct_pkg::S_FLUSH;
          end
        end
      end
      kct_pkg::S_FLUSH: begin
        if (!ostall) begin
          out_vld_d  = 1'b1;
          out_st_d   = kct_pkg::ST_REPORT;
          out_key_d  = pend_key_q;
          out_cnt_d  = pend_cnt_q;
          out_last_d = 1'b1;
          pend_vld_d = 1'b0;
          state_d    = kct_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = kct_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= kct_pkg::S_IDLE;
      used_q     <= '0;
      max_q      <= '0;
      stp_q      <= '0;
      n_q        <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      used_q     <= used_d;
      max_q      <= max_d;
      stp_q      <= stp_d;
      n_q        <= n_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    key_q      <= key_d;
    pend_key_q <= pend_key_d;
    pend_cnt_q <= pend_cnt_d;
    out_st_q   <= out_st_d;
    out_key_q  <= out_key_d;
    out_cnt_q  <= out_cnt_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_cnt_q, out_key_q[7:0], out_key_q[15:8]};
  assign m_axis_tuser  = out_st_q;
  assign m_axis_tlast  = out_last_q;

  `KCT_NEVER(a_used_bound, used_q > UW'(D))
  `KCT_ASSERT(a_one_hit, (state_q == kct_pkg::S_ONE) |-> $onehot0(hits))
  `KCT_ASSERT(a_flush_pend, (state_q == kct_pkg::S_FLUSH) |-> pend_vld_q)
  `KCT_ASSERT(a_max_empty, (used_q == '0) == (max_q == '0))

endmodule
`default_nettype wire

### design/kct_cell.sv
// One table slot: key and count, key match, saturating increment, ring shift.
// Depends on kct_pkg.
`default_nettype none
module kct_cell (
  input  wire logic                           clk_i,
  input  wire logic [kct_pkg::IDX_W-1:0]      idx_i,
  input  wire kct_pkg::cell_cmd_t             cmd_i,
  input  wire logic [kct_pkg::KEY_W-1:0]      nbr_key_i,
  input  wire logic [kct_pkg::COUNT_BITS-1:0] nbr_cnt_i,
  output logic      [kct_pkg::KEY_W-1:0]      key_o,
  output logic      [kct_pkg::COUNT_BITS-1:0] cnt_o,
  output logic                                hit_o,
  output logic      [kct_pkg::COUNT_BITS-1:0] inc_cnt_o
);

  logic [kct_pkg::KEY_W-1:0]      key_q, key_d;
  logic [kct_pkg::COUNT_BITS-1:0] cnt_q, cnt_d;
  logic                           in_use, at_tail;
  logic [kct_pkg::COUNT_BITS-1:0] sat_inc;

  assign in_use  = kct_pkg::USED_W'(idx_i) < cmd_i.used;
  assign at_tail = kct_pkg::USED_W'(idx_i) == cmd_i.used;
  assign hit_o   = in_use && (key_q == cmd_i.key);
  assign sat_inc = (&cnt_q) ? cnt_q : cnt_q + kct_pkg::COUNT_BITS'(1);
  assign inc_cnt_o = hit_o ? sat_inc : '0;

  always_comb begin
    key_d = key_q;
    cnt_d = cnt_q;
    if (cmd_i.shift) begin
      key_d = nbr_key_i;
      cnt_d = nbr_cnt_i;
    end else if (cmd_i.upd && hit_o) begin
      cnt_d = sat_inc;
    end else if (cmd_i.append && at_tail) begin
      key_d = cmd_i.key;
      cnt_d = kct_pkg::COUNT_BITS'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    cnt_q <= cnt_d;
  end

  assign key_o = key_q;
  assign cnt_o = cnt_q;

endmodule
`default_nettype wire

### test/key_count_table_with_mode_report_tb.sv
// Testbench for key_count_table_with_mode_report: random and directed count and report beats
// on the input stream, with a scoreboard class that predicts and checks each output beat.
// Depends on kct_pkg and the key_count_table_with_mode_report RTL.
`default_nettype none
module key_count_table_with_mode_report_tb;

  localparam int CYCLE_LIMIT = 5_000_000;

  typedef struct {
    kct_pkg::status_e status;
    logic [7:0]       key_first;
    logic [7:0]       key_second;
    logic [15:0]      count;
    logic             last;
  } tally_t;

  class tally_board;
    logic [kct_pkg::KEY_W-1:0]      keys   [kct_pkg::TABLE_DEPTH];
    logic [kct_pkg::COUNT_BITS-1:0] counts [kct_pkg::TABLE_DEPTH];
    int                             used;
    logic [kct_pkg::COUNT_BITS-1:0] top;
    tally_t                         expected_tallies [$];
    int                             errors;

    function new();
      used   = 0;
      top    = '0;
      errors = 0;
    endfunction

    function void push_tally(kct_pkg::status_e st, logic [kct_pkg::KEY_W-1:0] k,
                             logic [kct_pkg::COUNT_BITS-1:0] c, logic lst);
      tally_t t;
      t.status     = st;
      t.key_first  = k[15:8];
      t.key_second = k[7:0];
      t.count      = 16'(c);
      t.last       = lst;
      expected_tallies.push_back(t);
    endfunction

    function bit holds_key(logic [kct_pkg::KEY_W-1:0] k);
      for (int i = 0; i < used; i++)
        if (keys[i] == k) return 1'b1;
      return 1'b0;
    endfunction

    // update the table for one accepted beat and queue the beats it causes
    function void predict_tally(kct_pkg::op_e op, logic [7:0] f, logic [7:0] s);
      logic [kct_pkg::KEY_W-1:0] k;
      tally_t                    t;
      int                        n;
      n = 0;
      if (op == kct_pkg::OP_COUNT) begin
        if (f == 8'd0) s = 8'd0;
        k = {f, s};
        for (int i = 0; i < used; i++) begin
          if (keys[i] == k) begin
            if (counts[i] != '1) counts[i]++;
            if (counts[i] > top) top = counts[i];
            push_tally(kct_pkg::ST_EXISTING, k, counts[i], 1'b1);
            return;
          end
        end
        if (used >= kct_pkg::TABLE_DEPTH) begin
          push_tally(kct_pkg::ST_FULL, k, '0, 1'b1);
          return;
        end
        keys[used]   = k;
        counts[used] = kct_pkg::COUNT_BITS'(1);
        used++;
        if (top == '0) top = kct_pkg::COUNT_BITS'(1);
        push_tally(kct_pkg::ST_NEW, k, kct_pkg::COUNT_BITS'(1), 1'b1);
      end else begin
        for (int i = 0; i < used; i++) begin
          if (counts[i] == top && n < kct_pkg::REPORT_LIMIT) begin
            push_tally(kct_pkg::ST_REPORT, keys[i], counts[i], 1'b0);
            n++;
          end
        end
        if (n == 0) begin
          push_tally(kct_pkg::ST_EMPTY, '0, '0, 1'b1);
        end else begin
          t      = expected_tallies.pop_back();
          t.last = 1'b1;
          expected_tallies.push_back(t);
        end
      end
    endfunction

    function void check_result(tally_t got);
      tally_t exp_t;
      if (expected_tallies.size() == 0) begin
        $error("output beat with nothing expected: status %0d", got.status);
        errors++;
        return;
      end
      exp_t = expected_tallies.pop_front();
      if (got.status != exp_t.status) begin
        $error("status: expected %0d actual %0d", exp_t.status, got.status);
        errors++;
      end
      if (got.key_first != exp_t.key_first) begin
        $error("out_key_first: expected %0h actual %0h", exp_t.key_first, got.key_first);
        errors++;
      end
      if (got.key_second != exp_t.key_second) begin
        $error("out_key_second: expected %0h actual %0h", exp_t.key_second, got.key_second);
        errors++;
      end
      if (got.count != exp_t.count) begin
        $error("out_count: expected %0d actual %0d", exp_t.count, got.count);
        errors++;
      end
      if (got.last != exp_t.last) begin
        $error("last: expected %0d actual %0d", exp_t.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata  = '0;
  logic [0:0]  s_axis_tuser  = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  tally_board board;
  bit         quiet      = 1'b0;
  bit         calm       = 1'b0;
  int         stall_left = 0;

  key_count_table_with_mode_report DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(5, 30);
  endfunction

  // sink side back-pressure
  always @(posedge clk_i) begin
    if (quiet || calm) begin
      stall_left = 0;
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if ($urandom_range(0, 99) < 25) begin
      stall_left = gap_len() - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    tally_t got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status     = kct_pkg::status_e'(m_axis_tuser);
      got.key_first  = m_axis_tdata[7:0];
      got.key_second = m_axis_tdata[15:8];
      got.count      = m_axis_tdata[31:16];
      got.last       = m_axis_tlast;
      board.check_result(got);
    end
  end

  task automatic send_beat(input kct_pkg::op_e op, input logic [7:0] f, input logic [7:0] s);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {s, f};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    board.predict_tally(op, f, s);
    if ($urandom_range(0, 49) == 0) calm = !calm;
    if (!quiet && !calm && $urandom_range(0, 99) < 30) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap_len()) @(posedge clk_i);
    end
  endtask

  task automatic hit_entry(input int idx);
    logic [7:0] f;
    logic [7:0] s;
    f = board.keys[idx][15:8];
    s = (f == 8'd0) ? 8'($urandom) : board.keys[idx][7:0];
    send_beat(kct_pkg::OP_COUNT, f, s);
  endtask

  // count beat with a key not yet in the table
  task automatic fresh_beat();
    logic [7:0] f;
    logic [7:0] s;
    do begin
      f = 8'($urandom);
      s = 8'($urandom);
    end while (board.holds_key({f, (f == 8'd0) ? 8'd0 : s}));
    send_beat(kct_pkg::OP_COUNT, f, s);
  endtask

  task automatic random_beat();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10)
      send_beat(kct_pkg::OP_REPORT, 8'($urandom), 8'($urandom));
    else if (r < 55 && board.used > 0)
      hit_entry($urandom_range(0, board.used - 1));
    else if (r < 60)
      send_beat(kct_pkg::OP_COUNT, 8'd0, 8'($urandom));
    else
      send_beat(kct_pkg::OP_COUNT, 8'($urandom), 8'($urandom));
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("key_count_table_with_mode_report verification failed");
    $finish;
  end

  initial begin
    board = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table, empty keys, extreme characters, ties
    send_beat(kct_pkg::OP_REPORT, 8'h00, 8'h00);
    send_beat(kct_pkg::OP_COUNT, 8'h00, 8'hA5);
    send_beat(kct_pkg::OP_COUNT, 8'h00, 8'h00);
    send_beat(kct_pkg::OP_COUNT, 8'hFF, 8'hFF);
    send_beat(kct_pkg::OP_COUNT, 8'hFF, 8'h00);
    send_beat(kct_pkg::OP_COUNT, 8'h01, 8'hFF);
    send_beat(kct_pkg::OP_REPORT, 8'hFF, 8'hFF);
    send_beat(kct_pkg::OP_COUNT, 8'hFF, 8'hFF);
    send_beat(kct_pkg::OP_REPORT, 8'h00, 8'h00);
    send_beat(kct_pkg::OP_COUNT, 8'h55, 8'hAA);
    send_beat(kct_pkg::OP_COUNT, 8'hAA, 8'h55);
    send_beat(kct_pkg::OP_COUNT, 8'h00, 8'h5A);
    send_beat(kct_pkg::OP_REPORT, 8'h5A, 8'hA5);

    // fill up, then overflow
    while (board.used < kct_pkg::TABLE_DEPTH) fresh_beat();
    repeat (3) fresh_beat();
    send_beat(kct_pkg::OP_REPORT, 8'h00, 8'h00);

    // bring every entry to the maximum: report returns the whole table
    quiet = 1'b1;
    for (int i = 0; i < kct_pkg::TABLE_DEPTH; i++)
      while (board.counts[i] != board.top) hit_entry(i);
    send_beat(kct_pkg::OP_REPORT, 8'hFF, 8'hFF);
    quiet = 1'b0;

    repeat (270) random_beat();

    s_axis_tvalid <= 1'b0;
    while (board.expected_tallies.size() != 0) @(posedge clk_i);
    repeat (kct_pkg::TABLE_DEPTH + 8) @(posedge clk_i);
    if (board.errors == 0)
      $display("key_count_table_with_mode_report verification clean");
    else
      $display("key_count_table_with_mode_report verification failed");
    $finish;
  end
endmodule
`default_nettype wire
